@@ sv/fltpm_pkg.sv @@
// Package for the four-level page table mapper.
// Holds the request and result word types, status codes and defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fltpm_pkg;

    localparam int DEF_TABLE_SLOTS    = 256;
    localparam int DEF_MAX_PAGE_COUNT = 65535;
    localparam int ENTRIES_PER_TABLE  = 512;
    localparam int IDX_W              = 9;
    localparam int ENTRY_W            = 64;
    localparam int FRAME_W            = 40;
    localparam int VPAGE_W            = 36;
    localparam int COUNT_W            = 16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_TABLES = 3'd1;
    localparam logic [2:0] ST_HIT_1G    = 3'd2;
    localparam logic [2:0] ST_HIT_2M    = 3'd3;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd4;

    localparam logic [11:0] LINK_BITS = 12'h007;

    typedef struct packed {
        logic [7:0]  root_table;
        logic [35:0] virt_page;
        logic [39:0] phys_page;
        logic [15:0] page_count;
        logic [11:0] page_flags;
        logic        no_execute;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pages_mapped;
    } rsp_t;

endpackage

`default_nettype wire

@@ sv/four_level_page_table_mapper.sv @@
// Top level of the four-level page table mapper: walk sequencer and table store.
// Depends on fltpm_pkg and fltpm_table_ram.
//
//   Channel  Direction  Handshake            Word
//   cfg      in         cfg_valid/cfg_ready  cfg_data, table base frame
//   in       in         in_valid/in_ready    in_data, one map request
//   out      out        out_valid/out_ready  out_data, status and page count
//
// Each page passes through a start state, a read and an evaluate state per level (three
// levels) and a leaf write; each newly created table adds 512 clear writes and the link
// write, all through the single table store port.
// After reset the store is swept to zero, all TABLE_SLOTS * 512 entries (131072 by
// default), with in_ready low. A new request is taken once the result register is
// free; a stalled result does not hold up the walk.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_mapper #(
    parameter int TABLE_SLOTS    = fltpm_pkg::DEF_TABLE_SLOTS,
    parameter int MAX_PAGE_COUNT = fltpm_pkg::DEF_MAX_PAGE_COUNT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [39:0]     cfg_data,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire fltpm_pkg::req_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output fltpm_pkg::rsp_t      out_data
);

    import fltpm_pkg::*;

    localparam int SW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NW    = $clog2(TABLE_SLOTS + 1);
    localparam int AW    = SW + IDX_W;
    localparam int DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_START = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_EVAL  = 8'b0001_0000,
        S_CLEAR = 8'b0010_0000,
        S_LINK  = 8'b0100_0000,
        S_LEAF  = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [FRAME_W-1:0]   base_reg, base_next;
    logic [NW-1:0]        nfs_reg, nfs_next;
    logic [7:0]           root_reg, root_next;
    logic [VPAGE_W-1:0]   vpage_reg, vpage_next;
    logic [FRAME_W-1:0]   ppage_reg, ppage_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   done_reg, done_next;
    logic [11:0]          flags_reg, flags_next;
    logic                 nx_reg, nx_next;
    logic [1:0]           level_reg, level_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic [SW-1:0]        child_reg, child_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_data_reg, out_data_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [IDX_W-1:0]     lvl_idx;
    logic [FRAME_W-1:0]   ent_off;
    logic [FRAME_W-1:0]   new_frame;
    logic [COUNT_W-1:0]   req_count;
    logic [COUNT_W-1:0]   done_inc;
    logic                 finish;
    logic [2:0]           fin_status;
    logic [SW-1:0]        child_val;
    logic                 advance;

    fltpm_table_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        case (level_reg)
            2'd0:    lvl_idx = vpage_reg[35:27];
            2'd1:    lvl_idx = vpage_reg[26:18];
            default: lvl_idx = vpage_reg[17:9];
        endcase
    end

    assign ram_raddr = {slot_reg, lvl_idx};
    assign ent_off   = ram_rdata[51:12] - base_reg;
    assign new_frame = base_reg + FRAME_W'(nfs_reg);
    assign done_inc  = done_reg + 16'd1;
    assign req_count = (32'(in_data.page_count) > 32'(MAX_PAGE_COUNT)) ?
                       COUNT_W'(MAX_PAGE_COUNT) : in_data.page_count;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        base_next      = base_reg;
        nfs_next       = nfs_reg;
        root_next      = root_reg;
        vpage_next     = vpage_reg;
        ppage_next     = ppage_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        flags_next     = flags_reg;
        nx_next        = nx_reg;
        level_next     = level_reg;
        slot_next      = slot_reg;
        child_next     = child_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = clr_reg;
        ram_wdata      = '0;
        finish         = 1'b0;
        fin_status     = ST_OK;
        child_val      = ent_off[SW-1:0];
        advance        = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            base_next = cfg_data;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    root_next  = in_data.root_table;
                    vpage_next = in_data.virt_page;
                    ppage_next = in_data.phys_page;
                    flags_next = in_data.page_flags;
                    nx_next    = in_data.no_execute;
                    count_next = req_count;
                    done_next  = '0;
                    if (req_count == '0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                if (32'(root_reg) >= 32'(TABLE_SLOTS))
                begin
                    finish     = 1'b1;
                    fin_status = ST_BAD_ADDR;
                end
                else
                begin
                    slot_next  = SW'(root_reg);
                    level_next = 2'd0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!ram_rdata[0])
                begin
                    if (32'(nfs_reg) >= 32'(TABLE_SLOTS))
                    begin
                        finish     = 1'b1;
                        fin_status = ST_NO_TABLES;
                    end
                    else
                    begin
                        clr_next   = '0;
                        state_next = S_CLEAR;
                    end
                end
                else if ((level_reg != 2'd0) && ram_rdata[7])
                begin
                    finish     = 1'b1;
                    fin_status = (level_reg == 2'd1) ? ST_HIT_1G : ST_HIT_2M;
                end
                else if (ent_off >= FRAME_W'(TABLE_SLOTS))
                begin
                    finish     = 1'b1;
                    fin_status = ST_BAD_ADDR;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {nfs_reg[SW-1:0], clr_reg[IDX_W-1:0]};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg[IDX_W-1:0] == IDX_W'(ENTRIES_PER_TABLE - 1))
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                ram_we    = 1'b1;
                ram_waddr = {slot_reg, lvl_idx};
                ram_wdata = {12'd0, new_frame, LINK_BITS};
                child_val = nfs_reg[SW-1:0];
                nfs_next  = nfs_reg + 1'b1;
                advance   = 1'b1;
            end
            S_LEAF:
            begin
                ram_we    = 1'b1;
                ram_waddr = {child_reg, vpage_reg[8:0]};
                ram_wdata = {nx_reg, 11'd0, ppage_reg, flags_reg};
                done_next = done_inc;
                if (done_inc == count_reg)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    vpage_next = vpage_reg + 1'b1;
                    ppage_next = ppage_reg + 1'b1;
                    state_next = S_START;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            if (level_reg == 2'd2)
            begin
                child_next = child_val;
                state_next = S_LEAF;
            end
            else
            begin
                slot_next  = child_val;
                level_next = level_reg + 2'd1;
                state_next = S_READ;
            end
        end

        if (finish)
        begin
            out_valid_next             = 1'b1;
            out_data_next.status       = fin_status;
            out_data_next.pages_mapped = done_next;
            state_next                 = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            base_reg      <= '0;
            nfs_reg       <= NW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            base_reg      <= base_next;
            nfs_reg       <= nfs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg     <= root_next;
        vpage_reg    <= vpage_next;
        ppage_reg    <= ppage_next;
        count_reg    <= count_next;
        done_reg     <= done_next;
        flags_reg    <= flags_next;
        nx_reg       <= nx_next;
        level_reg    <= level_next;
        slot_reg     <= slot_next;
        child_reg    <= child_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

@@ sv/fltpm_table_ram.sv @@
// Table store of the page table mapper: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module fltpm_table_ram #(
    parameter int DEPTH = 131072,
    parameter int AW    = 17,
    parameter int DW    = 64
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/fltpm_checker.sv @@
// Port-level checks for the four-level page table mapper, bound to its top level.
// Depends on fltpm_pkg and four_level_page_table_mapper.
`timescale 1ns / 1ps
`default_nettype none

module fltpm_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire fltpm_pkg::rsp_t out_data
);

    import fltpm_pkg::*;

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status <= ST_BAD_ADDR))
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("request taken while result register full");

    a_ok_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready || out_valid)
        else $error("request taken without a walk or a result");

endmodule

bind four_level_page_table_mapper fltpm_checker u_fltpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

@@ dv/four_level_page_table_mapper_checker.sv @@
// Checker for the four-level page table mapper: watches the cfg, in and out channels.
// Keeps its own copy of the table store, predicts each result word and compares it.
// Depends on fltpm_pkg.
`timescale 1ns / 1ps

module four_level_page_table_mapper_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [39:0]       cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  fltpm_pkg::req_t   in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  fltpm_pkg::rsp_t   out_data,
    output int                fail_count,
    output int                pending
);

    import fltpm_pkg::*;

    localparam int SLOTS = DEF_TABLE_SLOTS;

    logic [63:0] tables [0:SLOTS*ENTRIES_PER_TABLE-1];
    int          next_slot;
    logic [39:0] base_frame;
    rsp_t        awaited_rsp [$];

    task automatic descend(input int slot, input int idx, input logic [2:0] large_st,
                           output logic [2:0] st, output int child);
        logic [63:0] ent;
        logic [39:0] frame;
        logic [39:0] off;
        int          pos;
        pos = slot * ENTRIES_PER_TABLE + idx;
        ent = tables[pos];
        st = ST_OK;
        child = 0;
        if (!ent[0])
        begin
            if (next_slot >= SLOTS)
            begin
                st = ST_NO_TABLES;
                return;
            end
            child = next_slot;
            next_slot++;
            for (int j = 0; j < ENTRIES_PER_TABLE; j++)
                tables[child*ENTRIES_PER_TABLE + j] = '0;
            frame = base_frame + 40'(child);
            tables[pos] = {12'b0, frame, LINK_BITS};
            return;
        end
        if (large_st != ST_OK && ent[7])
        begin
            st = large_st;
            return;
        end
        off = ent[51:12] - base_frame;
        if (off >= 40'(SLOTS))
            st = ST_BAD_ADDR;
        else
            child = int'(off);
    endtask

    task automatic map_pages(input req_t r, output rsp_t res);
        logic [2:0]  st;
        logic [15:0] done;
        logic [35:0] vp;
        logic [39:0] pf;
        int          l3;
        int          l2;
        int          l1;
        int          cnt;
        st = ST_OK;
        done = '0;
        cnt = r.page_count;
        if (cnt > DEF_MAX_PAGE_COUNT)
            cnt = DEF_MAX_PAGE_COUNT;
        for (int i = 0; i < cnt; i++)
        begin
            vp = r.virt_page + 36'(i);
            pf = r.phys_page + 40'(i);
            if (int'(r.root_table) >= SLOTS)
            begin
                st = ST_BAD_ADDR;
                break;
            end
            descend(int'(r.root_table), int'(vp[35:27]), ST_OK, st, l3);
            if (st != ST_OK)
                break;
            descend(l3, int'(vp[26:18]), ST_HIT_1G, st, l2);
            if (st != ST_OK)
                break;
            descend(l2, int'(vp[17:9]), ST_HIT_2M, st, l1);
            if (st != ST_OK)
                break;
            tables[l1*ENTRIES_PER_TABLE + int'(vp[8:0])] =
                {r.no_execute, 11'b0, pf, r.page_flags};
            done++;
        end
        res.status = st;
        res.pages_mapped = done;
    endtask

    assign pending = awaited_rsp.size();

    initial
    begin
        for (int k = 0; k < SLOTS*ENTRIES_PER_TABLE; k++)
            tables[k] = '0;
        next_slot = 1;
        base_frame = '0;
        fail_count = 0;
    end

    always @(posedge clk)
    begin
        rsp_t res;
        rsp_t exp_rsp;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                base_frame = cfg_data;
            if (in_valid && in_ready)
            begin
                map_pages(in_data, res);
                awaited_rsp.push_back(res);
            end
            if (out_valid && out_ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    exp_rsp = awaited_rsp.pop_front();
                    if (out_data.status !== exp_rsp.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_rsp.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.pages_mapped !== exp_rsp.pages_mapped)
                    begin
                        $display("%0t: pages_mapped expected %0d actual %0d", $time,
                                 exp_rsp.pages_mapped, out_data.pages_mapped);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ dv/four_level_page_table_mapper_test.sv @@
// Testbench top for the four-level page table mapper: clock, reset and stimulus.
// Directed walks through normal and error paths, then random phases under several table bases.
// Depends on fltpm_pkg, four_level_page_table_mapper and its checker.
`timescale 1ns / 1ps

module four_level_page_table_mapper_test;
    import fltpm_pkg::*;

    localparam int STALL_LIMIT = 400000;
    localparam logic [39:0] FRAME_MAX = 40'hFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [39:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    req_t        in_data;
    logic        out_valid;
    logic        out_ready;
    rsp_t        out_data;
    int          fail_count;
    int          pending;
    bit          idling;
    int          quiet_cycles;
    logic [39:0] cur_base;
    logic [35:0] regions [0:7];

    four_level_page_table_mapper DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    four_level_page_table_mapper_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (idling && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic write_base(input logic [39:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_base = v;
    endtask

    task automatic send_req(input req_t r);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic req_t mk_req(input logic [7:0] root, input logic [35:0] vp,
                                    input logic [39:0] pp, input logic [15:0] cnt,
                                    input logic [11:0] fl, input logic nx);
        req_t r;
        r.root_table = root;
        r.virt_page = vp;
        r.phys_page = pp;
        r.page_count = cnt;
        r.page_flags = fl;
        r.no_execute = nx;
        return r;
    endfunction

    function automatic req_t random_req();
        req_t        r;
        int          pick;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        r.root_table = (pick < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick < 8)
            r.virt_page = regions[$urandom_range(0, 7)] + 36'($urandom_range(0, 1200));
        else
            r.virt_page = raw[35:0];
        raw = {$urandom, $urandom};
        pick = $urandom_range(0, 3);
        if (pick < 2)
            r.phys_page = cur_base + 40'($urandom_range(0, 300));
        else
            r.phys_page = raw[39:0];
        pick = $urandom_range(0, 19);
        if (pick == 0)
            r.page_count = 16'd0;
        else if (pick == 1)
            r.page_count = 16'($urandom_range(13, 400));
        else
            r.page_count = 16'($urandom_range(1, 12));
        r.page_flags = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 1) == 1)
            r.page_flags[0] = 1'b1;
        r.no_execute = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
            send_req(random_req());
        drain();
    endtask

    initial
    begin
        logic [63:0] raw;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        idling = 1'b1;
        quiet_cycles = 0;
        cur_base = '0;
        for (int k = 0; k < 8; k++)
        begin
            raw = {$urandom, $urandom};
            regions[k] = {raw[35:11], 11'b0};
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_base(40'd0);
        send_req(mk_req(8'd0, 36'd0, 40'd1000, 16'd1, 12'h001, 1'b0));
        send_req(mk_req(8'd0, 36'd1, 40'd3, 16'd1, 12'h081, 1'b0));
        send_req(mk_req(8'd0, 36'd2, 40'd3, 16'd1, 12'h001, 1'b0));
        send_req(mk_req(8'd3, 36'd0, 40'd5, 16'hFFFF, 12'hFFF, 1'b1));
        send_req(mk_req(8'd3, (36'd1 << 27) | (36'd1 << 18), 40'd5, 16'hFFFF, 12'h0, 1'b0));
        send_req(mk_req(8'd3, (36'd1 << 27) | (36'd2 << 18) | (36'd1 << 9), 40'd5,
                        16'hFFFF, 12'h0, 1'b1));
        send_req(mk_req(8'd0, 36'd5, 40'd0, 16'd0, 12'h0, 1'b0));
        send_req(mk_req(8'd255, 36'hF_FFFF_FFFF, FRAME_MAX, 16'd2, 12'hFFF, 1'b1));
        send_req(mk_req(8'd1, 36'hA_AAAA_AAAA, 40'h55_5555_5555, 16'd3, 12'hAAA, 1'b0));
        send_req(mk_req(8'd2, 36'h5_5555_5555, 40'hAA_AAAA_AAAA, 16'd3, 12'h555, 1'b1));
        drain();

        write_base(FRAME_MAX);
        random_phase(300);
        raw = {$urandom, $urandom};
        write_base(raw[39:0]);
        random_phase(300);
        idling = 1'b0;
        write_base(40'd0);
        random_phase(400);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/fltpm_pkg.sv
sv/fltpm_table_ram.sv
sv/four_level_page_table_mapper.sv
sv/fltpm_checker.sv
dv/four_level_page_table_mapper_checker.sv
dv/four_level_page_table_mapper_test.sv
